FILE: rtl/ear_pkg.sv
// Shared types and constants for the epoch artifact rejection block.
// Holds the request payload structs, the reason codes and the sizing constants.
// No dependencies.
`default_nettype none

package ear_pkg;

    // Sizing
    localparam int MAX_CHANNELS = 512;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int IDX_W        = 9;
    localparam int SAMPLE_W     = 32;
    localparam int LIMIT_W      = 32;
    localparam int NUM_CLASSES  = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 2 * LIMIT_W;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Highest channel class that has limits (ECG); higher codes are skipped
    localparam logic [2:0] CLS_LAST_KNOWN = 3'd4;
    // Highest valid configuration register index (ecg_limits)
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 3'd4;

    typedef enum logic [1:0] {
        REASON_NONE      = 2'd0,
        REASON_TOO_LARGE = 2'd1,
        REASON_FLAT      = 2'd2
    } reason_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [2:0]                 channel_class;
        logic                       channel_is_bad;
        logic                       last_of_channel;
        logic                       last_of_epoch;
    } in_t;

    typedef struct packed {
        logic              accepted;
        logic [1:0]        reason_code;
        logic [IDX_W-1:0]  channel_index;
        logic [LIMIT_W-1:0] peak_to_peak;
    } out_t;

    // Finished channel handed from the tracker to the judge
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ch_min;
        logic signed [SAMPLE_W-1:0] ch_max;
        logic [2:0]                 cls;
        logic                       bad;
        logic [CH_W-1:0]            index;
        logic                       end_ep;
    } done_t;

endpackage

`default_nettype wire

FILE: rtl/ear_track.sv
// Per-channel min/max tracker and channel counter.
// Emits one finished-channel record per channel end. Depends on ear_pkg.
`default_nettype none

module ear_track (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          acc,
    input  wire ear_pkg::in_t  in_data,
    output logic               done_valid,
    output ear_pkg::done_t     done
);

    logic signed [ear_pkg::SAMPLE_W-1:0] min_reg, max_reg;
    logic signed [ear_pkg::SAMPLE_W-1:0] min_next, max_next;
    logic                                first_reg;
    logic [ear_pkg::CH_W-1:0]            cnt_reg, cnt_next;
    logic                                end_ch;
    logic                                done_valid_reg;
    ear_pkg::done_t                      done_reg;

    // Fold the new sample into the running extremes
    always_comb begin
        if (first_reg) begin
            min_next = in_data.sample_value;
            max_next = in_data.sample_value;
        end else begin
            min_next = (in_data.sample_value < min_reg) ? in_data.sample_value : min_reg;
            max_next = (in_data.sample_value > max_reg) ? in_data.sample_value : max_reg;
        end
    end

    assign end_ch = in_data.last_of_channel | in_data.last_of_epoch;

    // Saturate the channel counter at its top value; restart at epoch end
    always_comb begin
        if (in_data.last_of_epoch) begin
            cnt_next = '0;
        end else if (cnt_reg != ear_pkg::CH_W'(ear_pkg::MAX_CHANNELS - 1)) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // Track state and hand off finished channels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg      <= 1'b1;
            cnt_reg        <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            done_valid_reg <= 1'b0;
        end else begin
            done_valid_reg <= acc && end_ch;
            if (acc) begin
                if (end_ch) begin
                    first_reg <= 1'b1;
                    cnt_reg   <= cnt_next;
                end else begin
                    first_reg <= 1'b0;
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                end
            end
        end
    end

    // Channel record payload
    always_ff @(posedge aclk) begin
        if (acc && end_ch) begin
            done_reg.ch_min <= min_next;
            done_reg.ch_max <= max_next;
            done_reg.cls    <= in_data.channel_class;
            done_reg.bad    <= in_data.channel_is_bad;
            done_reg.index  <= cnt_reg;
            done_reg.end_ep <= in_data.last_of_epoch;
        end
    end

    assign done_valid = done_valid_reg;
    assign done       = done_reg;

endmodule

`default_nettype wire

FILE: rtl/ear_judge.sv
// Limit registers, per-channel limit check and epoch verdict.
// Produces one verdict request per epoch end. Depends on ear_pkg.
`default_nettype none

module ear_judge (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr,
    input  wire logic [ear_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ear_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           done_valid,
    input  wire ear_pkg::done_t                 done,
    output logic                                res_valid,
    output ear_pkg::out_t                       res
);

    logic [ear_pkg::CFG_DATA_W-1:0] limits_reg [ear_pkg::NUM_CLASSES];

    logic                          failed_reg, failed_next;
    ear_pkg::reason_t              reason_reg, reason_next, code;
    logic [ear_pkg::IDX_W-1:0]     chan_reg, chan_next;
    logic [ear_pkg::LIMIT_W-1:0]   peak_reg, peak_next;
    logic [ear_pkg::CFG_DATA_W-1:0] lim;
    logic [ear_pkg::LIMIT_W-1:0]   rej, flat, pp;
    logic                          known, check;
    logic                          res_valid_reg;
    ear_pkg::out_t                 res_reg;

    // Write limit registers; ignore indexes past the last class
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ear_pkg::NUM_CLASSES; i++) begin
                limits_reg[i] <= '0;
            end
        end else if (cfg_wr && (cfg_index <= ear_pkg::CFG_LAST_INDEX)) begin
            limits_reg[cfg_index] <= cfg_data;
        end
    end

    // Test the finished channel against its class limits
    always_comb begin
        known = (done.cls <= ear_pkg::CLS_LAST_KNOWN);
        lim   = known ? limits_reg[done.cls] : '0;
        rej   = lim[ear_pkg::CFG_DATA_W-1:ear_pkg::LIMIT_W];
        flat  = lim[ear_pkg::LIMIT_W-1:0];
        pp    = ear_pkg::LIMIT_W'(done.ch_max - done.ch_min);
        if ((rej != '0) && (pp > rej)) begin
            code = ear_pkg::REASON_TOO_LARGE;
        end else if ((flat != '0) && (pp < flat)) begin
            code = ear_pkg::REASON_FLAT;
        end else begin
            code = ear_pkg::REASON_NONE;
        end
        check = !failed_reg && !done.bad && known && (code != ear_pkg::REASON_NONE);

        // Keep the first failure only
        failed_next = failed_reg;
        reason_next = reason_reg;
        chan_next   = chan_reg;
        peak_next   = peak_reg;
        if (check) begin
            failed_next = 1'b1;
            reason_next = code;
            chan_next   = ear_pkg::IDX_W'(done.index);
            peak_next   = pp;
        end
    end

    // Update the verdict; clear it when the epoch closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failed_reg    <= 1'b0;
            reason_reg    <= ear_pkg::REASON_NONE;
            chan_reg      <= '0;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= done_valid && done.end_ep;
            if (done_valid) begin
                if (done.end_ep) begin
                    failed_reg <= 1'b0;
                    reason_reg <= ear_pkg::REASON_NONE;
                    chan_reg   <= '0;
                    peak_reg   <= '0;
                end else begin
                    failed_reg <= failed_next;
                    reason_reg <= reason_next;
                    chan_reg   <= chan_next;
                    peak_reg   <= peak_next;
                end
            end
        end
    end

    // Verdict request payload
    always_ff @(posedge aclk) begin
        if (done_valid && done.end_ep) begin
            res_reg.accepted      <= !failed_next;
            res_reg.reason_code   <= reason_next;
            res_reg.channel_index <= chan_next;
            res_reg.peak_to_peak  <= peak_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A verdict leaves the epoch state cleared
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> !failed_reg && (reason_reg == ear_pkg::REASON_NONE))
        else $error("verdict state not cleared at epoch end");

    // An accepted epoch reports no reason, channel or peak
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && res_reg.accepted |->
            (res_reg.reason_code == ear_pkg::REASON_NONE) &&
            (res_reg.channel_index == '0) && (res_reg.peak_to_peak == '0))
        else $error("accepted epoch carries failure fields");

    // A rejected epoch always names a reason
    a_reject_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !res_reg.accepted |->
            (res_reg.reason_code == ear_pkg::REASON_TOO_LARGE) ||
            (res_reg.reason_code == ear_pkg::REASON_FLAT))
        else $error("rejected epoch without reason");

endmodule

`default_nettype wire

FILE: rtl/ear_outq.sv
// Small result queue that decouples the verdict logic from the output port.
// Depends on ear_pkg.
`default_nettype none

module ear_outq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire ear_pkg::out_t              push_data,
    input  wire logic                       pop,
    output logic                            not_empty,
    output ear_pkg::out_t                   head,
    output logic [ear_pkg::OQ_CW-1:0]       count
);

    ear_pkg::out_t                  q_reg [ear_pkg::OQ_DEPTH];
    logic [ear_pkg::OQ_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [ear_pkg::OQ_CW-1:0]      count_reg;

    // Store pushed requests
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = q_reg[rd_ptr_reg];
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg != ear_pkg::OQ_CW'(ear_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ear_pkg::OQ_CW'(ear_pkg::OQ_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/epoch_artifact_rejection.sv
// A last_of_epoch sample's verdict passes the tracker and judge registers and the queue to m_*.
// Throughput: one sample per cycle, paced by free slots in the four-entry result queue
// (a slot is held for every verdict queued or still in the two pipeline registers).
// Configuration writes are never stalled; cfg_ready is always high.
// Reset (aresetn low, synchronous) clears the limits to zero, the epoch state and the queue.
// Top level: tracker, judge and result queue. Depends on ear_pkg, ear_track, ear_judge, ear_outq.
`default_nettype none

module epoch_artifact_rejection (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ear_pkg::in_t                   s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ear_pkg::out_t                       m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ear_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ear_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                          acc;
    logic                          done_valid;
    ear_pkg::done_t                done;
    logic                          res_valid;
    ear_pkg::out_t                 res;
    logic                          pop;
    logic [ear_pkg::OQ_CW-1:0]     q_count;
    logic [ear_pkg::OQ_CW:0]       reserved;

    // Hold input while queued plus in-flight verdicts fill the queue
    assign reserved = (ear_pkg::OQ_CW+1)'(q_count)
                    + (ear_pkg::OQ_CW+1)'(done_valid && done.end_ep)
                    + (ear_pkg::OQ_CW+1)'(res_valid);
    assign s_ready  = (reserved < (ear_pkg::OQ_CW+1)'(ear_pkg::OQ_DEPTH));
    assign acc      = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign pop      = m_valid && m_ready;

    ear_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .acc        (acc),
        .in_data    (s_data),
        .done_valid (done_valid),
        .done       (done)
    );

    ear_judge u_judge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done_valid (done_valid),
        .done       (done),
        .res_valid  (res_valid),
        .res        (res)
    );

    ear_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .not_empty (m_valid),
        .head      (m_data),
        .count     (q_count)
    );

endmodule

`default_nettype wire
